>>> rtl/ptq_pkg.sv
// shared types and constants for the priority task queue
package ptq_pkg;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // item modes
  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_EXEC
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ptq_cmd_t;

endpackage

>>> rtl/ptq_ctrl.sv
// sequencing controller: input handshake, execute step and result valid
module ptq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output ptq_pkg::ptq_cmd_t cmd
);
  import ptq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        slot_free;

  // result register free now or emptied at this edge
  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTRL_IDLE: begin
        if (in_valid && slot_free) state_nxt = CTRL_EXEC;
      end
      CTRL_EXEC: begin
        state_nxt = CTRL_IDLE;
      end
      default: begin
        state_nxt = CTRL_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      CTRL_IDLE: begin
        in_stall    = !slot_free;
        cmd.capture = in_valid && slot_free;
      end
      CTRL_EXEC: begin
        cmd.execute = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTRL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/ptq_datapath.sv
// sorted shift-register cells, occupancy count and result register
module ptq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ptq_pkg::ptq_cmd_t            cmd,
  input  logic                         in_mode,
  input  logic [ptq_pkg::ID_W-1:0]     in_task_id,
  input  logic [ptq_pkg::PRIO_W-1:0]   in_prio_value,
  input  logic [ptq_pkg::BURST_W-1:0]  in_burst_len,
  output logic [ptq_pkg::STAT_W-1:0]   out_status,
  output logic [ptq_pkg::ID_W-1:0]     out_id,
  output logic [ptq_pkg::PRIO_W-1:0]   out_prio,
  output logic [ptq_pkg::BURST_W-1:0]  out_burst,
  output logic [ptq_pkg::OCC_W-1:0]    out_occupancy
);
  import ptq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // item register
  logic               mode_r;
  logic [ID_W-1:0]    tid_r;
  logic [PRIO_W-1:0]  pr_r;
  logic [BURST_W-1:0] bu_r;

  // cells, entry 0 is the head
  logic [ID_W-1:0]    id_r    [QUEUE_DEPTH];
  logic [PRIO_W-1:0]  prio_r  [QUEUE_DEPTH];
  logic [BURST_W-1:0] burst_r [QUEUE_DEPTH];
  logic [ID_W-1:0]    id_nxt    [QUEUE_DEPTH];
  logic [PRIO_W-1:0]  prio_nxt  [QUEUE_DEPTH];
  logic [BURST_W-1:0] burst_nxt [QUEUE_DEPTH];

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [QUEUE_DEPTH-1:0] stay;  // cell holds an entry that stays ahead of the new one
  logic          is_full;
  logic          is_empty;

  logic [STAT_W-1:0]  status_r,  status_nxt;
  logic [ID_W-1:0]    oid_r,     oid_nxt;
  logic [PRIO_W-1:0]  oprio_r,   oprio_nxt;
  logic [BURST_W-1:0] oburst_r,  oburst_nxt;

  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  // per-cell compare against the new priority
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      stay[k] = (CW'(k) < count_r) && (prio_r[k] <= pr_r);
    end
  end

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      id_nxt[k]    = id_r[k];
      prio_nxt[k]  = prio_r[k];
      burst_nxt[k] = burst_r[k];
    end
    count_nxt  = count_r;
    status_nxt = status_r;
    oid_nxt    = oid_r;
    oprio_nxt  = oprio_r;
    oburst_nxt = oburst_r;
    if (cmd.execute) begin
      status_nxt = ST_OK;
      oid_nxt    = '0;
      oprio_nxt  = '0;
      oburst_nxt = '0;
      if (mode_r == MODE_INSERT) begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (!stay[k]) begin
              if (k == 0 || stay[(k == 0) ? 0 : k - 1]) begin
                id_nxt[k]    = tid_r;
                prio_nxt[k]  = pr_r;
                burst_nxt[k] = bu_r;
              end else begin
                id_nxt[k]    = id_r[(k == 0) ? 0 : k - 1];
                prio_nxt[k]  = prio_r[(k == 0) ? 0 : k - 1];
                burst_nxt[k] = burst_r[(k == 0) ? 0 : k - 1];
              end
            end
          end
        end
      end else begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt  = count_r - 1'b1;
          oid_nxt    = id_r[0];
          oprio_nxt  = prio_r[0];
          oburst_nxt = burst_r[0];
          for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            id_nxt[k]    = id_r[k + 1];
            prio_nxt[k]  = prio_r[k + 1];
            burst_nxt[k] = burst_r[k + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      tid_r  <= in_task_id;
      pr_r   <= in_prio_value;
      bu_r   <= in_burst_len;
    end
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      id_r[k]    <= id_nxt[k];
      prio_r[k]  <= prio_nxt[k];
      burst_r[k] <= burst_nxt[k];
    end
    status_r <= status_nxt;
    oid_r    <= oid_nxt;
    oprio_r  <= oprio_nxt;
    oburst_r <= oburst_nxt;
  end

  // occupancy reported in a fixed-width field, wraps for deep queues
  logic [OCC_W-1:0] occ_r;
  always_ff @(posedge clk) begin
    if (cmd.execute) occ_r <= OCC_W'(count_nxt);
  end

  assign out_status    = status_r;
  assign out_id        = oid_r;
  assign out_prio      = oprio_r;
  assign out_burst     = oburst_r;
  assign out_occupancy = occ_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (mode_r == MODE_INSERT) && !is_full
      |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("accepted insert did not grow the queue");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (mode_r == MODE_DISPATCH) && is_empty |=> status_r == ST_EMPTY)
    else $error("dispatch on empty queue not flagged");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(2) |-> prio_r[0] <= prio_r[1])
    else $error("head entries out of order");
`endif

endmodule

>>> rtl/priority_task_queue_top.sv
// top level of the priority task queue scheduler
// Priority task queue. Keeps up to QUEUE_DEPTH tasks in a row of shift-register
// cells sorted by ascending priority value; the smallest value is at the head and
// tasks of equal priority leave in arrival order. An insert beat (mode 0) places
// the task behind every entry of smaller or equal priority; status 1 flags an
// insert into a full queue, which leaves the queue unchanged. A dispatch beat
// (mode 1) removes the head and returns its id, priority and burst; status 2
// flags a dispatch on an empty queue. Every input beat gives exactly one result
// beat carrying the occupancy after the item (5-bit field, wraps above 31).
// Each item first loads the item register; then all cells compare and shift in
// parallel and the result register loads. No new beat is accepted while an item
// executes. The controller accepts a beat only while the result register is
// empty or being taken in the same cycle.
// The queue is empty after reset; no clearing pass is needed.
module priority_task_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [ptq_pkg::ID_W-1:0]     in_task_id,
  input  logic [ptq_pkg::PRIO_W-1:0]   in_prio_value,
  input  logic [ptq_pkg::BURST_W-1:0]  in_burst_len,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ptq_pkg::STAT_W-1:0]   out_status,
  output logic [ptq_pkg::ID_W-1:0]     out_id,
  output logic [ptq_pkg::PRIO_W-1:0]   out_prio,
  output logic [ptq_pkg::BURST_W-1:0]  out_burst,
  output logic [ptq_pkg::OCC_W-1:0]    out_occupancy
);
  import ptq_pkg::*;

  // command bundle from the controller
  ptq_cmd_t cmd;

  // handshake and sequencing
  ptq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // sorted cells and result register
  ptq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_task_id    (in_task_id),
    .in_prio_value (in_prio_value),
    .in_burst_len  (in_burst_len),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_prio      (out_prio),
    .out_burst     (out_burst),
    .out_occupancy (out_occupancy)
  );

endmodule
